// ===== rtl/core/dtbl_pkg.sv =====
// Shared types, widths and codes for the dual token bucket limiter.
package dtbl_pkg;

    localparam int TIME_W    = 48;
    localparam int TOKEN_W   = 32;
    localparam int RATE_W    = 24;
    localparam int SIZE_W    = 16;
    localparam int ELAPSED_W = 32;
    localparam int CFG_W     = 32;
    localparam int CNT_W     = $clog2(TOKEN_W);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic                 CMD_START   = 1'b0;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic [SIZE_W-1:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic               allowed;
        logic [TOKEN_W-1:0] committed_level;
        logic [TOKEN_W-1:0] excess_level;
    } t_out_item;

    typedef enum logic [1:0] {
        CFG_C_BURST = 2'd0,
        CFG_C_RATE  = 2'd1,
        CFG_E_BURST = 2'd2,
        CFG_E_RATE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_ELAPSED,
        DP_CHECK,
        DP_APPLY,
        DP_TAKE,
        DP_OUT
    } t_dp_op;

    typedef enum logic {
        BKT_COMMIT,
        BKT_EXCESS
    } t_bucket;

    typedef struct packed {
        t_dp_op  op;
        t_bucket sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic skip;
        logic time_zero;
        logic div_done;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_C_CHECK,
        ST_C_WAIT,
        ST_E_CHECK,
        ST_E_WAIT,
        ST_TAKE,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/core/dtbl_div.sv =====
// Radix-2 restoring divider that turns free space and rate into whole milliseconds.
module dtbl_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [dtbl_pkg::TOKEN_W-1:0]    i_dividend,
    input  logic [dtbl_pkg::RATE_W-1:0]     i_divisor,
    output logic [dtbl_pkg::TOKEN_W-1:0]    o_quotient,
    output logic                            o_done
);
    import dtbl_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [RATE_W-1:0]  r_rem;
    logic [RATE_W-1:0]  r_den;
    logic [TOKEN_W-1:0] r_quo;

    logic [RATE_W:0]    trial;
    logic [RATE_W:0]    diff;
    logic               ge;
    logic [RATE_W-1:0]  n_rem;
    logic [TOKEN_W-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[TOKEN_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        n_quo = {r_quo[TOKEN_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TOKEN_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/core/dtbl_dp.sv =====
// Datapath with configuration registers, bucket levels, refill arithmetic and output register.
module dtbl_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  dtbl_pkg::t_cfg_idx           i_cfg_index,
    input  logic [dtbl_pkg::CFG_W-1:0]   i_cfg_data,
    input  dtbl_pkg::t_in_item           i_data,
    input  dtbl_pkg::t_dp_cmd            i_cmd,
    output dtbl_pkg::t_dp_status         o_status,
    output dtbl_pkg::t_out_item          o_data
);
    import dtbl_pkg::*;

    logic [TOKEN_W-1:0]   r_c_burst;
    logic [RATE_W-1:0]    r_c_rate;
    logic [TOKEN_W-1:0]   r_e_burst;
    logic [RATE_W-1:0]    r_e_rate;
    logic [TIME_W-1:0]    r_last;
    logic [TOKEN_W-1:0]   r_c_lvl;
    logic [TOKEN_W-1:0]   r_e_lvl;

    logic                 r_cmd;
    logic [TIME_W-1:0]    r_now;
    logic [SIZE_W-1:0]    r_size;
    logic [ELAPSED_W-1:0] r_time;
    logic [TOKEN_W-1:0]   r_prod;
    logic                 r_allowed;
    t_out_item            r_out;

    logic [TOKEN_W-1:0]          lvl;
    logic [TOKEN_W-1:0]          burst;
    logic [RATE_W-1:0]           rate;
    logic [TOKEN_W-1:0]          space;
    logic                        full;
    logic                        rate_zero;
    logic [TIME_W-1:0]           gap;
    logic [ELAPSED_W-1:0]        elapsed;
    logic [ELAPSED_W+RATE_W-1:0] prod_full;
    logic [TOKEN_W-1:0]          need;
    logic                        div_done;
    logic                        div_start;
    logic                        covers;
    logic [TOKEN_W-1:0]          n_lvl;
    logic [TOKEN_W-1:0]          size_ext;

    always_comb begin
        lvl       = (i_cmd.sel == BKT_EXCESS) ? r_e_lvl : r_c_lvl;
        burst     = (i_cmd.sel == BKT_EXCESS) ? r_e_burst : r_c_burst;
        rate      = (i_cmd.sel == BKT_EXCESS) ? r_e_rate : r_c_rate;
        full      = lvl >= burst;
        space     = burst - lvl;
        rate_zero = rate == '0;
        div_start = (i_cmd.op == DP_CHECK) && !full && !rate_zero;
        prod_full = r_time * rate;
        gap       = r_now - r_last;
        elapsed   = (gap > TIME_W'(ELAPSED_MAX)) ? ELAPSED_MAX : gap[ELAPSED_W-1:0];
        covers    = r_time >= need;
        n_lvl     = covers ? burst : lvl + r_prod;
        size_ext  = TOKEN_W'(r_size);
    end

    dtbl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (space),
        .i_divisor  (rate),
        .o_quotient (need),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_burst <= '0;
            r_c_rate  <= '0;
            r_e_burst <= '0;
            r_e_rate  <= '0;
            r_last    <= '0;
            r_c_lvl   <= '0;
            r_e_lvl   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_C_BURST: r_c_burst <= i_cfg_data[TOKEN_W-1:0];
                    CFG_C_RATE:  r_c_rate  <= i_cfg_data[RATE_W-1:0];
                    CFG_E_BURST: r_e_burst <= i_cfg_data[TOKEN_W-1:0];
                    CFG_E_RATE:  r_e_rate  <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                DP_START: begin
                    r_last  <= r_now;
                    r_c_lvl <= r_c_burst;
                    r_e_lvl <= '0;
                end
                DP_ELAPSED: begin
                    if (r_now > r_last) begin
                        r_last <= r_now;
                    end
                end
                DP_APPLY: begin
                    if (i_cmd.sel == BKT_EXCESS) begin
                        r_e_lvl <= n_lvl;
                    end else begin
                        r_c_lvl <= n_lvl;
                    end
                end
                DP_TAKE: begin
                    if (size_ext <= r_c_lvl) begin
                        r_c_lvl <= r_c_lvl - size_ext;
                    end else if (size_ext <= r_e_lvl) begin
                        r_e_lvl <= r_e_lvl - size_ext;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_cmd  <= i_data.command;
                r_now  <= i_data.now_ms;
                r_size <= i_data.request_size;
            end
            DP_START: begin
                r_allowed <= 1'b1;
            end
            DP_ELAPSED: begin
                r_time <= (r_now > r_last) ? elapsed : '0;
            end
            DP_CHECK: begin
                r_prod <= prod_full[TOKEN_W-1:0];
                if (!full && rate_zero) begin
                    r_time <= '0;
                end
            end
            DP_APPLY: begin
                r_time <= covers ? r_time - need : '0;
            end
            DP_TAKE: begin
                r_allowed <= (size_ext <= r_c_lvl) || (size_ext <= r_e_lvl);
            end
            DP_OUT: begin
                r_out.allowed         <= r_allowed;
                r_out.committed_level <= r_c_lvl;
                r_out.excess_level    <= r_e_lvl;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.is_start  = r_cmd == CMD_START;
        o_status.skip      = full || rate_zero;
        o_status.time_zero = r_time == '0;
        o_status.div_done  = div_done;
    end

    assign o_data = r_out;

endmodule

// ===== rtl/core/dtbl_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module dtbl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  dtbl_pkg::t_dp_status  i_status,
    output dtbl_pkg::t_dp_cmd     o_cmd
);
    import dtbl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = DP_NOP;
        o_cmd.sel   = BKT_COMMIT;
        o_stall     = 1'b1;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_start) begin
                    o_cmd.op = DP_START;
                    n_state  = ST_FINISH;
                end else begin
                    o_cmd.op = DP_ELAPSED;
                    n_state  = ST_C_CHECK;
                end
            end
            ST_C_CHECK: begin
                o_cmd.op = DP_CHECK;
                n_state  = i_status.skip ? ST_E_CHECK : ST_C_WAIT;
            end
            ST_C_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = DP_APPLY;
                    n_state  = ST_E_CHECK;
                end
            end
            ST_E_CHECK: begin
                o_cmd.sel = BKT_EXCESS;
                if (i_status.time_zero) begin
                    n_state = ST_TAKE;
                end else begin
                    o_cmd.op = DP_CHECK;
                    n_state  = i_status.skip ? ST_TAKE : ST_E_WAIT;
                end
            end
            ST_E_WAIT: begin
                o_cmd.sel = BKT_EXCESS;
                if (i_status.div_done) begin
                    o_cmd.op = DP_APPLY;
                    n_state  = ST_TAKE;
                end
            end
            ST_TAKE: begin
                o_cmd.op = DP_TAKE;
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_out_valid;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_DECODE))
        else $error("accepted item did not move to decode");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_OUT) |-> !(r_out_valid && i_stall))
        else $error("output register overwritten while held");

    a_commit_to_excess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C_WAIT && i_status.div_done) |=> (r_state == ST_E_CHECK))
        else $error("committed refill did not hand over to excess bucket");

    a_out_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == ST_FINISH))
        else $error("result shown without finishing an item");

endmodule

// ===== rtl/core/dual_token_bucket_limiter_core.sv =====
// Top level of the dual token bucket limiter: controller, datapath and configuration port.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_valid / o_stall         i_data  (command, now_ms, request_size)
//   output    out        o_valid / i_stall         o_data  (allowed, levels)
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A start item goes from decode straight to finish. A request item's duration is set by
// the shared one-bit-per-cycle divider, run once for each bucket that is neither full nor
// at zero rate (the excess one only with time left); the controller waits for each run.
// Reset is synchronous and clears configuration, time base and both levels to zero.
// A new item is taken while a finished result waits in the output register; a stalled
// output only holds back the end of the following item.
module dual_token_bucket_limiter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  dtbl_pkg::t_in_item          i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output dtbl_pkg::t_out_item         o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  dtbl_pkg::t_cfg_idx          i_cfg_index,
    input  logic [dtbl_pkg::CFG_W-1:0]  i_cfg_data
);
    import dtbl_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    dtbl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    dtbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_data      (o_data)
    );

endmodule

// ===== tb/dtbl_verdict_check.sv =====
`timescale 1ns / 1ps
// Checker that predicts the limiter's verdicts and bucket levels and compares them with the outputs.
module dtbl_verdict_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  dtbl_pkg::t_in_item         i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  dtbl_pkg::t_out_item        i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  dtbl_pkg::t_cfg_idx         i_cfg_index,
    input  logic [dtbl_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_verdicts_due,
    output int                         o_allowed_count,
    output int                         o_denied_count
);
    import dtbl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [TOKEN_W-1:0] c_burst;
    logic [RATE_W-1:0]  c_rate;
    logic [TOKEN_W-1:0] e_burst;
    logic [RATE_W-1:0]  e_rate;
    logic [TIME_W-1:0]  time_base;
    logic [TOKEN_W-1:0] c_level;
    logic [TOKEN_W-1:0] e_level;

    t_out_item verdict_q[$];
    t_out_item want;
    int        fail_total;
    int        result_index;
    int        allowed_total;
    int        denied_total;

    task automatic refill_bucket(inout logic [TOKEN_W-1:0] level,
                                 input logic [TOKEN_W-1:0] burst,
                                 input logic [RATE_W-1:0] rate,
                                 inout logic [ELAPSED_W-1:0] ms);
        logic [TOKEN_W-1:0] need;
        logic [63:0]        gain;
        if (level < burst) begin
            if (rate == '0) begin
                ms = '0;
            end else begin
                need = (burst - level) / rate;
                if (ms >= need) begin
                    level = burst;
                    ms = ms - need;
                end else begin
                    gain = ms * rate;
                    level = level + gain[TOKEN_W-1:0];
                    ms = '0;
                end
            end
        end
    endtask

    task automatic police_item(input t_in_item it, output t_out_item verdict);
        logic [TIME_W-1:0]    gap;
        logic [ELAPSED_W-1:0] ms;
        verdict.allowed = 1'b1;
        if (it.command == CMD_START) begin
            time_base = it.now_ms;
            c_level = c_burst;
            e_level = '0;
        end else begin
            gap = '0;
            if (it.now_ms > time_base) begin
                gap = it.now_ms - time_base;
                time_base = it.now_ms;
            end
            ms = ((gap >> ELAPSED_W) != '0) ? ELAPSED_MAX : gap[ELAPSED_W-1:0];
            refill_bucket(c_level, c_burst, c_rate, ms);
            if (ms != '0) begin
                refill_bucket(e_level, e_burst, e_rate, ms);
            end
            if (it.request_size <= c_level) begin
                c_level = c_level - it.request_size;
            end else if (it.request_size <= e_level) begin
                e_level = e_level - it.request_size;
            end else begin
                verdict.allowed = 1'b0;
            end
        end
        verdict.committed_level = c_level;
        verdict.excess_level = e_level;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_burst = '0;
            c_rate = '0;
            e_burst = '0;
            e_rate = '0;
            time_base = '0;
            c_level = '0;
            e_level = '0;
            verdict_q.delete();
            fail_total = 0;
            result_index = 0;
            allowed_total = 0;
            denied_total = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("Unexpected result %0d: allowed=%0b committed=%0d excess=%0d",
                                 result_index, i_out_data.allowed,
                                 i_out_data.committed_level, i_out_data.excess_level);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data.allowed !== want.allowed ||
                        i_out_data.committed_level !== want.committed_level ||
                        i_out_data.excess_level !== want.excess_level) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display({"Mismatch on result %0d: expected allowed=%0b ",
                                      "committed=%0d excess=%0d, got allowed=%0b ",
                                      "committed=%0d excess=%0d"},
                                     result_index, want.allowed, want.committed_level,
                                     want.excess_level, i_out_data.allowed,
                                     i_out_data.committed_level, i_out_data.excess_level);
                        end
                    end
                end
                if (i_out_data.allowed === 1'b1) begin
                    allowed_total++;
                end else begin
                    denied_total++;
                end
                result_index++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_C_BURST: c_burst = i_cfg_data[TOKEN_W-1:0];
                    CFG_C_RATE:  c_rate = i_cfg_data[RATE_W-1:0];
                    CFG_E_BURST: e_burst = i_cfg_data[TOKEN_W-1:0];
                    CFG_E_RATE:  e_rate = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                police_item(i_in_data, want);
                verdict_q.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_verdicts_due <= verdict_q.size();
        o_allowed_count <= allowed_total;
        o_denied_count <= denied_total;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the limiter testbench: clock, reset, stimulus, receiver stalls and the verdict.
module tb;
    import dtbl_pkg::*;

    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_PHASE     = 3;

    localparam logic               CMD_REQUEST = 1'b1;
    localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
    localparam logic [CFG_W-1:0]   TOKEN_MAX   = '1;
    localparam logic [CFG_W-1:0]   RATE_MAX    = (1 << RATE_W) - 1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX    = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_in_item           i_data;
    logic               o_valid;
    logic               i_stall;
    t_out_item          o_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    int fail_count;
    int verdicts_due;
    int allowed_count;
    int denied_count;

    int  send_gap_mode = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    logic hold_req = 1'b0;
    int  holds_done = 0;
    int  items_sent = 0;
    int  starts_sent = 0;
    int  configs_loaded = 0;
    int  idle_cycles = 0;

    dual_token_bucket_limiter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    dtbl_verdict_check checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_data       (i_data),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_data      (o_data),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_verdicts_due  (verdicts_due),
        .o_allowed_count (allowed_count),
        .o_denied_count  (denied_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_item make_item(input logic cmd, input logic [TIME_W-1:0] now,
                                           input logic [SIZE_W-1:0] size);
        t_in_item it;
        it.command = cmd;
        it.now_ms = now;
        it.request_size = size;
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] pick_burst();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return TOKEN_MAX;
            2: return $urandom;
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RATE_MAX;
            2: return $urandom_range(0, RATE_MAX);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    task automatic offer_item(input t_in_item it);
        int gap;
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (it.command == CMD_START) starts_sent++;
        if (send_gap_mode != 0) begin
            if (burst_left == 0) begin
                gap = (send_gap_mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 25);
                burst_left = (send_gap_mode == 1) ? $urandom_range(1, 16) : $urandom_range(1, 3);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic end_phase();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [CFG_W-1:0] cb, input logic [CFG_W-1:0] cr,
                               input logic [CFG_W-1:0] eb, input logic [CFG_W-1:0] er);
        cfg_write(CFG_C_BURST, cb);
        cfg_write(CFG_C_RATE, cr);
        cfg_write(CFG_E_BURST, eb);
        cfg_write(CFG_E_RATE, er);
        i_cfg_valid <= 1'b0;
        configs_loaded++;
    endtask

    task automatic run_phase(input int n_items);
        logic [TIME_W-1:0] clock_ms;
        t_in_item          it;
        clock_ms = ($urandom_range(0, 3) == 0) ? TIME_MAX - TIME_W'($urandom_range(0, 5000))
                                               : TIME_W'({$urandom, $urandom});
        offer_item(make_item(CMD_START, clock_ms, SIZE_W'($urandom)));
        for (int k = 1; k < n_items; k++) begin
            it.command = CMD_REQUEST;
            case ($urandom_range(0, 19))
                0: begin
                    clock_ms = TIME_W'({$urandom, $urandom});
                    it.command = CMD_START;
                    it.now_ms = clock_ms;
                end
                1: it.now_ms = clock_ms - TIME_W'($urandom_range(0, 100));
                2: begin
                    clock_ms = clock_ms + TIME_W'({$urandom_range(1, 3), $urandom});
                    it.now_ms = clock_ms;
                end
                3, 4, 5: begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 100000));
                    it.now_ms = clock_ms;
                end
                default: begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 20));
                    it.now_ms = clock_ms;
                end
            endcase
            case ($urandom_range(0, 7))
                0: it.request_size = '0;
                1: it.request_size = SIZE_MAX;
                2, 3: it.request_size = SIZE_W'($urandom);
                default: it.request_size = SIZE_W'($urandom_range(0, 2000));
            endcase
            offer_item(it);
        end
    endtask

    initial begin
        logic stalled;
        int   run_left;
        stalled = 1'b0;
        run_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && holds_done == 0) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end
            if (stall_mode == 0) begin
                stalled = 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalled = !stalled;
                    case (stall_mode)
                        1: run_left = stalled ? $urandom_range(1, 3) : $urandom_range(1, 12);
                        2: run_left = stalled ? $urandom_range(1, 20) : $urandom_range(1, 4);
                        default: run_left = $urandom_range(1, 2);
                    endcase
                end
                run_left--;
            end
            i_stall <= stalled;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, verdicts_due);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_C_BURST;
        i_cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_mode = 1;
        stall_mode = 1;
        offer_item(make_item(CMD_REQUEST, 48'd5, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'd7, 16'd1));
        end_phase();

        load_limits(1000, 10, 500, 5);
        offer_item(make_item(CMD_START, 48'd100, SIZE_MAX));
        offer_item(make_item(CMD_REQUEST, 48'd100, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'd100, 16'd1000));
        offer_item(make_item(CMD_REQUEST, 48'd100, 16'd1));
        offer_item(make_item(CMD_REQUEST, 48'd150, 16'd600));
        offer_item(make_item(CMD_REQUEST, 48'd400, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'd400, 16'd800));
        offer_item(make_item(CMD_REQUEST, 48'd400, 16'd400));
        offer_item(make_item(CMD_REQUEST, 48'd300, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'h2_0000_0190, SIZE_MAX));
        offer_item(make_item(CMD_REQUEST, TIME_MAX, 16'd0));
        end_phase();

        load_limits(TOKEN_MAX, 0, TOKEN_MAX, RATE_MAX);
        offer_item(make_item(CMD_START, TIME_MAX, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'd0, 16'd1));
        offer_item(make_item(CMD_START, 48'd0, SIZE_MAX));
        offer_item(make_item(CMD_REQUEST, 48'd0, SIZE_MAX));
        offer_item(make_item(CMD_REQUEST, 48'd10, 16'd0));
        end_phase();

        load_limits(1000, RATE_MAX, 0, 0);
        offer_item(make_item(CMD_START, 48'd50, 16'd0));
        offer_item(make_item(CMD_REQUEST, 48'd50, 16'd999));
        offer_item(make_item(CMD_REQUEST, 48'd50, 16'd0));
        end_phase();

        load_limits(10, RATE_MAX, 0, 0);
        offer_item(make_item(CMD_REQUEST, 48'd50, 16'd5));
        end_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_limits(pick_burst(), pick_rate(), pick_burst(), pick_rate());
            send_gap_mode = p % 3;
            stall_mode = (p + 1) % 4;
            if (p == HOLD_PHASE) hold_req = 1'b1;
            run_phase(PHASE_ITEMS);
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Policed %0d items (%0d starts) under %0d limit settings: %0d allowed, %0d denied.",
                 items_sent, starts_sent, configs_loaded, allowed_count, denied_count);
        $display("Receiver held off %0d time(s) for %0d cycles; %0d mismatches seen.",
                 holds_done, HOLD_CYCLES, fail_count);
        if (fail_count == 0 && verdicts_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dtbl_pkg.sv
rtl/core/dtbl_div.sv
rtl/core/dtbl_dp.sv
rtl/core/dtbl_ctrl.sv
rtl/core/dual_token_bucket_limiter_core.sv
tb/dtbl_verdict_check.sv
tb/tb.sv
